// File: src/ubag_pkg.sv
// shared types, codes and microcode rom for the bag table
`default_nettype none

package ubag_pkg;

  // operation codes carried on mode
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  typedef logic [2:0] step_t;
  typedef logic [2:0] cond_t;

  // microprogram step addresses
  localparam step_t ST_WAIT    = 3'd0;
  localparam step_t ST_START   = 3'd1;
  localparam step_t ST_SCAN    = 3'd2;
  localparam step_t ST_DRAIN   = 3'd3;
  localparam step_t ST_DECIDE  = 3'd4;
  localparam step_t ST_MOVE_RD = 3'd5;
  localparam step_t ST_MOVE_WR = 3'd6;
  localparam step_t ST_RESULT  = 3'd7;

  // jump conditions
  localparam cond_t C_NEVER      = 3'd0;
  localparam cond_t C_NOT_ACCEPT = 3'd1;
  localparam cond_t C_EMPTY      = 3'd2;
  localparam cond_t C_MORE       = 3'd3;
  localparam cond_t C_NO_MOVE    = 3'd4;
  localparam cond_t C_OUT_BUSY   = 3'd5;

  // one control word
  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  take_in;
    logic  scan_init;
    logic  rd_scan;
    logic  cmp;
    logic  decide;
    logic  rd_last;
    logic  wr_move;
    logic  load_out;
  } ctl_t;

  // status flags fed back to the sequencer
  typedef struct packed {
    logic accept;
    logic empty;
    logic more;
    logic no_move;
    logic out_busy;
  } stat_t;

  // microcode rom
  function automatic ctl_t ucode(input step_t s);
    ctl_t c;
    c = '0;
    c.cond = C_NEVER;
    c.target = ST_WAIT;
    case (s)
      ST_WAIT: begin
        c.take_in = 1'b1;
        c.cond = C_NOT_ACCEPT;
        c.target = ST_WAIT;
      end
      ST_START: begin
        c.scan_init = 1'b1;
        c.cond = C_EMPTY;
        c.target = ST_DECIDE;
      end
      ST_SCAN: begin
        c.rd_scan = 1'b1;
        c.cmp = 1'b1;
        c.cond = C_MORE;
        c.target = ST_SCAN;
      end
      ST_DRAIN: begin
        c.cmp = 1'b1;
      end
      ST_DECIDE: begin
        c.decide = 1'b1;
        c.cond = C_NO_MOVE;
        c.target = ST_RESULT;
      end
      ST_MOVE_RD: begin
        c.rd_last = 1'b1;
      end
      ST_MOVE_WR: begin
        c.wr_move = 1'b1;
      end
      ST_RESULT: begin
        c.load_out = 1'b1;
        c.cond = C_OUT_BUSY;
        c.target = ST_RESULT;
      end
      default: begin
        c.cond = C_NEVER;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/ubag_seq.sv
// microcode sequencer: step counter, rom lookup and conditional jumps
`default_nettype none

module ubag_seq
  import ubag_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire stat_t stat,
  output ctl_t       ctl
);

  step_t step;
  step_t step_next;
  logic  jump;

  // control word for the current step
  assign ctl = ucode(step);

  // jump condition select
  always_comb begin
    case (ctl.cond)
      C_NEVER:      jump = 1'b0;
      C_NOT_ACCEPT: jump = !stat.accept;
      C_EMPTY:      jump = stat.empty;
      C_MORE:       jump = stat.more;
      C_NO_MOVE:    jump = stat.no_move;
      C_OUT_BUSY:   jump = stat.out_busy;
      default:      jump = 1'b0;
    endcase
    step_next = jump ? ctl.target : step_t'(step + 3'd1);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// File: src/ubag_datapath.sv
// entry memory, scan counters, match compare and count update
`default_nettype none

module ubag_datapath
  import ubag_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = $clog2(CAPACITY + 1),
  parameter int AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ctl_t          ctl,
  input  wire logic          accept,
  input  wire logic [1:0]    mode,
  input  wire logic [31:0]   entry_value,
  output logic               empty,
  output logic               more,
  output logic               no_move,
  output logic               ok_res,
  output logic [CW-1:0]      freq,
  output logic [CW-1:0]      count
);

  logic [1:0]             mode_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [CW-1:0]          idx;
  logic [AW-1:0]          pidx;
  logic                   pend;
  logic                   found;
  logic [AW-1:0]          first_idx;
  logic [63:0]            value_wide;
  logic [CW-1:0]          last_pos;

  // entry memory, one write and one registered read port
  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic                   we;

  assign value_wide = {32'd0, entry_value};
  assign last_pos   = count - CW'(1);

  // status for the sequencer
  assign empty   = (count == '0);
  assign more    = (CW'(idx + CW'(1)) != count);
  assign no_move = !((mode_q == MODE_REMOVE) && found);

  // memory port muxing
  always_comb begin
    raddr = ctl.rd_last ? last_pos[AW-1:0] : idx[AW-1:0];
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = value_q;
    if (ctl.decide && (mode_q == MODE_ADD) && (count < CW'(CAPACITY))) begin
      we = 1'b1;
    end
    if (ctl.wr_move) begin
      we    = 1'b1;
      waddr = first_idx;
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode;
      value_q <= value_wide[VALUE_WIDTH-1:0];
    end
  end

  // scan: issue one read per cycle, compare the previous read
  always_ff @(posedge clk) begin
    if (ctl.scan_init) begin
      idx   <= '0;
      pend  <= 1'b0;
      freq  <= '0;
      found <= 1'b0;
    end else begin
      if (ctl.cmp && pend && (rdata == value_q)) begin
        freq <= freq + CW'(1);
        if (!found) begin
          found     <= 1'b1;
          first_idx <= pidx;
        end
      end
      if (ctl.rd_scan) begin
        pidx <= idx[AW-1:0];
        pend <= 1'b1;
        idx  <= idx + CW'(1);
      end
    end
  end

  // count and success flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ok_res <= 1'b0;
    end else if (ctl.decide) begin
      case (mode_q)
        MODE_ADD: begin
          if (count < CW'(CAPACITY)) begin
            count  <= count + CW'(1);
            ok_res <= 1'b1;
          end else begin
            ok_res <= 1'b0;
          end
        end
        MODE_REMOVE: ok_res <= found;
        MODE_QUERY:  ok_res <= 1'b1;
        MODE_CLEAR: begin
          count  <= '0;
          ok_res <= 1'b1;
        end
        default: ok_res <= 1'b1;
      endcase
    end else if (ctl.wr_move) begin
      count <= last_pos;
    end
  end

endmodule

`default_nettype wire

// File: src/unordered_bag_table.sv
// Bag table top level: unordered multiset of values with add, remove,
// query and clear requests.
//
// Input channel in_valid/in_ready carries mode and entry_value; output
// channel out_valid/out_ready carries ok, frequency, present, size_now and
// is_empty. Exactly one result is returned per request, in order.
//
// A microcoded sequencer walks the stored entries through the single read
// port of the entry memory, one entry per cycle, then compares the last read,
// decides and stages the result. The result is registered as the sequencer
// leaves its final step, when in_ready also returns; a remove that finds its
// value first reads the last entry and writes it into the freed slot.
//
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver stalls with a result still pending, the sequencer
// holds its final step until that register frees.
//
// Reset empties the store, drops any pending result and holds in_ready low.
// No memory clearing is needed: only entries below the count are ever compared or moved.
`default_nettype none

module unordered_bag_table
  import ubag_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] entry_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic [4:0]       frequency,
  output logic             present,
  output logic [4:0]       size_now,
  output logic             is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  ctl_t          ctl;
  stat_t         stat;
  logic          accept;
  logic          out_busy;
  logic          ok_res;
  logic [CW-1:0] freq;
  logic [CW-1:0] count;
  logic          empty;
  logic          more;
  logic          no_move;

  assign in_ready = ctl.take_in && !rst;
  assign accept   = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;

  // status bundle for the sequencer
  assign stat.accept   = accept;
  assign stat.empty    = empty;
  assign stat.more     = more;
  assign stat.no_move  = no_move;
  assign stat.out_busy = out_busy;

  ubag_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  ubag_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          (CW),
    .AW          (AW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .accept      (accept),
    .mode        (mode),
    .entry_value (entry_value),
    .empty       (empty),
    .more        (more),
    .no_move     (no_move),
    .ok_res      (ok_res),
    .freq        (freq),
    .count       (count)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out && !out_busy) begin
      ok        <= ok_res;
      frequency <= 5'(freq);
      present   <= (freq != '0);
      size_now  <= 5'(count);
      is_empty  <= (count == '0);
    end
  end

  // count stays within capacity
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an accepted request closes the input until its result is staged
  assert property (@(posedge clk) disable iff (rst) accept |=> !in_ready)
    else $error("input reopened right after accept");

  // a move only happens with at least one stored entry
  assert property (@(posedge clk) disable iff (rst) ctl.wr_move |-> count != '0)
    else $error("entry move with empty store");

  // a staged result shows up as valid on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (ctl.load_out && !out_busy) |=> out_valid)
    else $error("result load did not raise out_valid");

  // frequency never exceeds the capacity
  assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> freq <= CW'(CAPACITY))
    else $error("frequency above capacity");

endmodule

`default_nettype wire
